// ===== rtl/core/keyt_pkg.sv =====
// Shared types and constants of the key event tracker.
package keyt_pkg;

  localparam int KEYS        = 5;
  localparam int HOLD_WIDTH  = 32;
  localparam int COUNT_WIDTH = 8;

  localparam int PIN_KEYS  = 4;
  localparam int KEY_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int KEY_EXT_W = 5;
  localparam int ADD_W     = 9;
  localparam int SUM_W     = HOLD_WIDTH + ADD_W;
  localparam int TOUCH_KEY = KEYS - 1;
  localparam int LAST_PIN  = KEYS - 2;

  localparam logic [1:0] REQ_SCAN  = 2'd0;
  localparam logic [1:0] REQ_TOUCH = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] REG_ACTIVE_HIGH_MASK = 2'd0;
  localparam logic [1:0] REG_SCAN_PERIOD_MS   = 2'd1;
  localparam logic [1:0] REG_TOUCH_THRESHOLD  = 2'd2;

  localparam logic [3:0]  RST_ACTIVE_HIGH_MASK = 4'd8;
  localparam logic [7:0]  RST_SCAN_PERIOD_MS   = 8'd5;
  localparam logic [15:0] RST_TOUCH_THRESHOLD  = 16'd40;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  pin_levels;
    logic [15:0] capture_value;
    logic [2:0]  key_index;
  } in_item_t;

  typedef struct packed {
    logic        is_pressed;
    logic        went_down;
    logic        went_up;
    logic [31:0] hold_time_ms;
    logic [7:0]  release_count;
  } out_item_t;

  typedef struct packed {
    logic                   pressed;
    logic                   down;
    logic                   up;
    logic [HOLD_WIDTH-1:0]  hold;
    logic [COUNT_WIDTH-1:0] count;
  } key_rec_t;

endpackage

// ===== rtl/core/key_event_tracker.sv =====
// Top level of the key event tracker: sequencer, key state registers, ports.
//
// Tracks four pin keys and one capacitive touch key. The input channel
// (in_valid/in_ready/in_data) carries one request per transaction: a scan
// tick with raw pin levels, a touch capture with a charge-time count, or a
// read of one key's state. Only a read produces a transaction on the result
// channel (out_valid/out_ready/out_data); it returns the key's flags, hold
// time and release count and clears that key's down and up flags.
// Timing: a scan tick walks the pin keys one per cycle through the single
// shared update unit; a touch capture passes the touch key through the same
// unit, and a read loads the output register. in_ready is low while a
// request is being worked on.
// The result sits in an output register, so a new request is accepted while
// an earlier result still waits; a read that finds that register still full
// holds until the receiver takes the pending result.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while the block is idle. Indexes past the last register
// are dropped.
// Reset (rst_n low, synchronous) clears all key state and the output valid
// flag, and loads the register defaults: mask 8, scan period 5 ms, threshold 40.
module key_event_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  keyt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output keyt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_TOUCH = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [keyt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [3:0] pins_r;
  logic       touch_hit_r;

  logic [3:0]  mask_r;
  logic [7:0]  period_r;
  logic [15:0] thresh_r;

  keyt_pkg::key_rec_t keys_r [keyt_pkg::KEYS];
  keyt_pkg::key_rec_t cur_key;
  keyt_pkg::key_rec_t upd_key;

  logic                         out_valid_r;
  keyt_pkg::out_item_t          out_data_r;

  logic                         in_fire;
  logic                         out_free;
  logic                         sample_pressed;
  logic [keyt_pkg::ADD_W-1:0]   add_ms;
  logic [keyt_pkg::KEY_EXT_W-1:0] key_ext;
  logic [keyt_pkg::KEY_EXT_W-1:0] idx_ext;
  logic                         pin_level;
  logic                         pin_high_act;
  logic                         write_en;
  logic                         read_done;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign cur_key = keys_r[key_r];
  assign key_ext = keyt_pkg::KEY_EXT_W'(key_r);
  assign idx_ext = keyt_pkg::KEY_EXT_W'(in_data.key_index);

  // Keys past the four pins see a low level with low-active sense.
  always_comb begin
    pin_level    = 1'b0;
    pin_high_act = 1'b0;
    if (key_ext < keyt_pkg::KEY_EXT_W'(keyt_pkg::PIN_KEYS)) begin
      pin_level    = pins_r[key_ext[1:0]];
      pin_high_act = mask_r[key_ext[1:0]];
    end
  end

  always_comb begin
    if (state_r == ST_TOUCH) begin
      sample_pressed = touch_hit_r;
      add_ms         = {period_r, 1'b0};
    end else begin
      sample_pressed = (pin_level == pin_high_act);
      add_ms         = keyt_pkg::ADD_W'(period_r);
    end
  end

  keyt_update u_update (
    .cur            (cur_key),
    .sample_pressed (sample_pressed),
    .add_ms         (add_ms),
    .nxt            (upd_key)
  );

  assign write_en  = (state_r == ST_SCAN) || (state_r == ST_TOUCH);
  assign read_done = (state_r == ST_READ) && out_free;

  // Sequencer: pick the start key on accept, advance through pin keys on scan.
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.req_type)
            keyt_pkg::REQ_SCAN: begin
              state_nxt = ST_SCAN;
              key_nxt   = '0;
            end
            keyt_pkg::REQ_TOUCH: begin
              state_nxt = ST_TOUCH;
              key_nxt   = keyt_pkg::KEY_W'(keyt_pkg::TOUCH_KEY);
            end
            keyt_pkg::REQ_READ: begin
              state_nxt = ST_READ;
              key_nxt   = (idx_ext < keyt_pkg::KEY_EXT_W'(keyt_pkg::KEYS)) ?
                          keyt_pkg::KEY_W'(in_data.key_index) : '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (key_r == keyt_pkg::KEY_W'(keyt_pkg::LAST_PIN)) begin
          state_nxt = ST_IDLE;
        end else begin
          key_nxt = key_r + keyt_pkg::KEY_W'(1);
        end
      end
      ST_TOUCH: begin
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r   <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  // Capture request operands; compare the touch count once on accept.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pins_r      <= in_data.pin_levels;
      touch_hit_r <= (in_data.capture_value > thresh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= keyt_pkg::RST_ACTIVE_HIGH_MASK;
      period_r <= keyt_pkg::RST_SCAN_PERIOD_MS;
      thresh_r <= keyt_pkg::RST_TOUCH_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        keyt_pkg::REG_ACTIVE_HIGH_MASK: mask_r   <= cfg_data[3:0];
        keyt_pkg::REG_SCAN_PERIOD_MS:   period_r <= cfg_data[7:0];
        keyt_pkg::REG_TOUCH_THRESHOLD:  thresh_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Key state: write back the update unit, or clear flags after a read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < keyt_pkg::KEYS; k++) begin
        keys_r[k] <= '0;
      end
    end else if (write_en) begin
      keys_r[key_r] <= upd_key;
    end else if (read_done) begin
      keys_r[key_r].down <= 1'b0;
      keys_r[key_r].up   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (read_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_done) begin
      out_data_r.is_pressed    <= cur_key.pressed;
      out_data_r.went_down     <= cur_key.down;
      out_data_r.went_up       <= cur_key.up;
      out_data_r.hold_time_ms  <= 32'(cur_key.hold);
      out_data_r.release_count <= 8'(cur_key.count);
    end
  end

endmodule

// ===== rtl/core/keyt_update.sv =====
// Shared key update unit: one adder for hold time, one incrementer for release count.
module keyt_update (
  input  keyt_pkg::key_rec_t          cur,
  input  logic                        sample_pressed,
  input  logic [keyt_pkg::ADD_W-1:0]  add_ms,
  output keyt_pkg::key_rec_t          nxt
);

  logic [keyt_pkg::HOLD_WIDTH-1:0]  hold_base;
  logic [keyt_pkg::SUM_W-1:0]       hold_sum;
  logic [keyt_pkg::COUNT_WIDTH-1:0] count_inc;

  // A new press restarts the hold time from zero.
  assign hold_base = cur.pressed ? cur.hold : '0;
  assign hold_sum  = keyt_pkg::SUM_W'(hold_base) + keyt_pkg::SUM_W'(add_ms);
  assign count_inc = cur.count + keyt_pkg::COUNT_WIDTH'(1);

  always_comb begin
    nxt = cur;
    if (sample_pressed) begin
      nxt.pressed = 1'b1;
      if (!cur.pressed) begin
        nxt.down = 1'b1;
      end
      nxt.hold = hold_sum[keyt_pkg::HOLD_WIDTH-1:0];
    end else if (cur.pressed) begin
      nxt.pressed = 1'b0;
      nxt.up      = 1'b1;
      // Skip zero on wrap.
      nxt.count   = (count_inc == '0) ? keyt_pkg::COUNT_WIDTH'(1) : count_inc;
    end
  end

endmodule
